// File: rtl/wtrm_pkg.sv
package wtrm_pkg;

  localparam int RANGE_W    = 16;
  localparam int AZ_W       = 15;
  localparam int GATE_W     = 16;
  localparam int FRAC_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int TDATA_W    = 32;

  localparam logic [CFG_IDX_W-1:0] REG_AZ_GATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTLIER = 2'd1;

  localparam logic [GATE_W-1:0] AZ_GATE_RST = 16'd42;
  localparam logic [FRAC_W-1:0] OUTLIER_RST = 8'd13;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: rtl/wtrm_front.sv
module wtrm_front #(
  parameter int HALF_WINDOW = 3
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  accept_i,
  input  logic [wtrm_pkg::RANGE_W-1:0]          range_mm_i,
  input  logic [wtrm_pkg::AZ_W-1:0]             azimuth_i,
  input  logic                                  row_start_i,
  output logic                                  push_o,
  output logic [(2*HALF_WINDOW+1)*(wtrm_pkg::RANGE_W+wtrm_pkg::AZ_W)-1:0] push_data_o
);
  import wtrm_pkg::*;

  localparam int WIN_LEN = 2 * HALF_WINDOW + 1;
  localparam int CNT_W   = $clog2(WIN_LEN + 1);

  logic [RANGE_W-1:0] range_q [WIN_LEN];
  logic [AZ_W-1:0]    az_q    [WIN_LEN];
  logic [RANGE_W-1:0] range_d [WIN_LEN];
  logic [AZ_W-1:0]    az_d    [WIN_LEN];
  logic [CNT_W-1:0]   fill_q, fill_d;

  always_comb begin
    for (int k = 0; k < WIN_LEN - 1; k++) begin
      range_d[k] = range_q[k+1];
      az_d[k]    = az_q[k+1];
    end
    range_d[WIN_LEN-1] = range_mm_i;
    az_d[WIN_LEN-1]    = azimuth_i;
    if (row_start_i) begin
      fill_d = CNT_W'(1);
    end else if (fill_q == CNT_W'(WIN_LEN)) begin
      fill_d = fill_q;
    end else begin
      fill_d = fill_q + CNT_W'(1);
    end
  end

  always_comb begin
    for (int k = 0; k < WIN_LEN; k++) begin
      push_data_o[k*RANGE_W +: RANGE_W]             = range_d[k];
      push_data_o[WIN_LEN*RANGE_W + k*AZ_W +: AZ_W] = az_d[k];
    end
  end

  assign push_o = accept_i && (fill_d == CNT_W'(WIN_LEN));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (accept_i) begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      for (int k = 0; k < WIN_LEN; k++) begin
        range_q[k] <= range_d[k];
        az_q[k]    <= az_d[k];
      end
    end
  end

endmodule

// File: rtl/wtrm_queue.sv
module wtrm_queue #(
  parameter int WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  logic [WIDTH-1:0]        push_data_i,
  input  logic                    pop_i,
  output logic [WIDTH-1:0]        pop_data_o,
  output wtrm_pkg::q_status_t     status_o
);
  import wtrm_pkg::*;

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;

  assign status_o.full  = (count_q == 2'd2);
  assign status_o.empty = (count_q == 2'd0);
  assign pop_data_o     = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !status_o.full || pop_i)
    else $error("queue overflow");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty)
    else $error("queue underflow");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("queue count out of range");

endmodule

// File: rtl/wtrm_div.sv
module wtrm_div #(
  parameter int SUM_W = 19,
  parameter int CNT_W = 3
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [SUM_W-1:0]             dividend_i,
  input  logic [CNT_W-1:0]             divisor_i,
  output logic                         done_o,
  output logic [wtrm_pkg::RANGE_W-1:0] quot_o
);
  import wtrm_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic               busy_q, done_q;
  logic [STEP_W-1:0]  step_q;
  logic [SUM_W-1:0]   dvd_q, dvd_d;
  logic [CNT_W-1:0]   dsr_q, rem_q, rem_d;
  logic [RANGE_W-1:0] quot_q;
  logic [CNT_W:0]     trial;
  logic               ge;

  always_comb begin
    trial = {rem_q, dvd_q[SUM_W-1]};
    ge    = trial >= {1'b0, dsr_q};
    rem_d = ge ? CNT_W'(trial - {1'b0, dsr_q}) : CNT_W'(trial);
    dvd_d = {dvd_q[SUM_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(SUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
      if (step_q == STEP_W'(SUM_W - 1)) begin
        quot_q <= (dsr_q == '0) ? '0 : dvd_d[RANGE_W-1:0];
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// File: rtl/wtrm_back.sv
module wtrm_back #(
  parameter int HALF_WINDOW = 3
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [wtrm_pkg::GATE_W-1:0]           az_gate_i,
  input  logic [wtrm_pkg::FRAC_W-1:0]           outlier_frac_i,
  input  wtrm_pkg::q_status_t                   q_status_i,
  input  logic [(2*HALF_WINDOW+1)*(wtrm_pkg::RANGE_W+wtrm_pkg::AZ_W)-1:0] q_data_i,
  output logic                                  pop_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [wtrm_pkg::RANGE_W-1:0]          mean_range_o,
  output logic [wtrm_pkg::AZ_W-1:0]             centre_azimuth_o
);
  import wtrm_pkg::*;

  localparam int WIN_LEN = 2 * HALF_WINDOW + 1;
  localparam int CNT_W   = $clog2(WIN_LEN + 1);
  localparam int IDX_W   = $clog2(WIN_LEN);
  localparam int SUM_W   = RANGE_W + CNT_W;
  localparam int THR_W   = RANGE_W + FRAC_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM1 = 3'd1;
  localparam logic [2:0] S_DIV1 = 3'd2;
  localparam logic [2:0] S_SUM2 = 3'd3;
  localparam logic [2:0] S_DIV2 = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]         state_q;
  logic [RANGE_W-1:0] range_q [WIN_LEN];
  logic [AZ_W-1:0]    az_q    [WIN_LEN];
  logic [AZ_W-1:0]    centre_q;
  logic [IDX_W-1:0]   idx_q;
  logic [SUM_W-1:0]   sum_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [RANGE_W-1:0] m1_q, mean_q;
  logic [THR_W-1:0]   thr_q;
  logic               start_q;
  logic               out_valid_q;
  logic [RANGE_W-1:0] out_mean_q;
  logic [AZ_W-1:0]    out_az_q;

  logic               div_done;
  logic [RANGE_W-1:0] div_quot;
  logic [AZ_W+1:0]    az_diff, az_abs;
  logic [RANGE_W-1:0] cur_range;
  logic               gated, excess, last_idx, out_load;

  wtrm_div #(
    .SUM_W(SUM_W),
    .CNT_W(CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_q),
    .dividend_i (sum_q),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    cur_range = range_q[idx_q];
    az_diff   = {{2{az_q[idx_q][AZ_W-1]}}, az_q[idx_q]}
              - {{2{centre_q[AZ_W-1]}}, centre_q};
    az_abs    = az_diff[AZ_W+1] ? (~az_diff + (AZ_W+2)'(1)) : az_diff;
    gated     = az_abs <= (AZ_W+2)'(az_gate_i);
    excess    = (cur_range > m1_q)
              && ({cur_range - m1_q, {FRAC_W{1'b0}}} > thr_q);
    last_idx  = idx_q == IDX_W'(WIN_LEN - 1);
  end

  assign pop_o    = (state_q == S_IDLE) && !q_status_i.empty;
  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      start_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (pop_o) begin
            state_q <= S_SUM1;
          end
        end
        S_SUM1: begin
          if (last_idx) begin
            state_q <= S_DIV1;
            start_q <= 1'b1;
          end
        end
        S_DIV1: begin
          if (div_done) begin
            state_q <= S_SUM2;
          end
        end
        S_SUM2: begin
          if (last_idx) begin
            state_q <= S_DIV2;
            start_q <= 1'b1;
          end
        end
        S_DIV2: begin
          if (div_done) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (pop_o) begin
          for (int k = 0; k < WIN_LEN; k++) begin
            range_q[k] <= q_data_i[k*RANGE_W +: RANGE_W];
            az_q[k]    <= q_data_i[WIN_LEN*RANGE_W + k*AZ_W +: AZ_W];
          end
          centre_q <= q_data_i[WIN_LEN*RANGE_W + HALF_WINDOW*AZ_W +: AZ_W];
        end
        idx_q <= '0;
        sum_q <= '0;
        cnt_q <= '0;
      end
      S_SUM1, S_SUM2: begin
        if (gated && !(state_q == S_SUM2 && excess)) begin
          sum_q <= sum_q + SUM_W'(cur_range);
          cnt_q <= cnt_q + CNT_W'(1);
        end
        idx_q <= idx_q + IDX_W'(1);
      end
      S_DIV1: begin
        if (div_done) begin
          m1_q  <= div_quot;
          thr_q <= THR_W'(div_quot) * THR_W'(outlier_frac_i);
          idx_q <= '0;
          sum_q <= '0;
          cnt_q <= '0;
        end
      end
      S_DIV2: begin
        if (div_done) begin
          mean_q <= div_quot;
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_mean_q <= mean_q;
          out_az_q   <= centre_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign mean_range_o     = out_mean_q;
  assign centre_azimuth_o = out_az_q;

  a_div_start_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q |-> cnt_q != '0 && cnt_q <= CNT_W'(WIN_LEN))
    else $error("divide started with bad count");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV1 || state_q == S_DIV2)
    else $error("divider done outside a divide phase");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> state_q == S_SUM1)
    else $error("pop did not start accumulation");

  a_mean_le_m1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV2 && div_done |=> mean_q <= m1_q + ((thr_q >> FRAC_W) + 1'b1))
    else $error("trimmed mean exceeds threshold");

endmodule

// File: rtl/window_trimmed_range_mean_top.sv
// Input words are taken every cycle while the two-entry window queue has room.
// In the back end a serial accumulator walks each full window twice, and a
// one-bit-per-cycle divider forms each mean.
// Reset clears the window fill count, queue, sequencer and output valid; config
// registers return to azimuth_gate=42 and outlier_fraction=13.
module window_trimmed_range_mean_top #(
  parameter int HALF_WINDOW = 3
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [wtrm_pkg::TDATA_W-1:0]      s_axis_tdata,  // range_mm[15:0], azimuth[30:16]
  input  logic                              s_axis_tuser,  // row_start
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [wtrm_pkg::TDATA_W-1:0]      m_axis_tdata,  // mean_range[15:0], centre_azimuth[30:16]
  input  logic                              cfg_we_i,
  input  logic [wtrm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [wtrm_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import wtrm_pkg::*;

  localparam int WIN_LEN = 2 * HALF_WINDOW + 1;
  localparam int Q_W     = WIN_LEN * (RANGE_W + AZ_W);

  logic [GATE_W-1:0]  az_gate_q;
  logic [FRAC_W-1:0]  outlier_q;
  logic               accept, push, pop;
  logic [Q_W-1:0]     push_data, pop_data;
  q_status_t          q_status;
  logic [RANGE_W-1:0] mean_range;
  logic [AZ_W-1:0]    centre_az;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      az_gate_q <= AZ_GATE_RST;
      outlier_q <= OUTLIER_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_AZ_GATE) begin
        az_gate_q <= cfg_data_i[GATE_W-1:0];
      end else if (cfg_idx_i == REG_OUTLIER) begin
        outlier_q <= cfg_data_i[FRAC_W-1:0];
      end
    end
  end

  assign s_axis_tready = !q_status.full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  wtrm_front #(
    .HALF_WINDOW(HALF_WINDOW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .range_mm_i  (s_axis_tdata[RANGE_W-1:0]),
    .azimuth_i   (s_axis_tdata[RANGE_W +: AZ_W]),
    .row_start_i (s_axis_tuser),
    .push_o      (push),
    .push_data_o (push_data)
  );

  wtrm_queue #(
    .WIDTH(Q_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_status)
  );

  wtrm_back #(
    .HALF_WINDOW(HALF_WINDOW)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .az_gate_i        (az_gate_q),
    .outlier_frac_i   (outlier_q),
    .q_status_i       (q_status),
    .q_data_i         (pop_data),
    .pop_o            (pop),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .mean_range_o     (mean_range),
    .centre_azimuth_o (centre_az)
  );

  assign m_axis_tdata = {{(TDATA_W - RANGE_W - AZ_W){1'b0}}, centre_az, mean_range};

endmodule

// File: dv/window_trimmed_range_mean_top_tb.sv
module window_trimmed_range_mean_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wtrm_pkg::*;

  localparam int HALF_WINDOW = 3;
  localparam int WIN_LEN     = 2 * HALF_WINDOW + 1;
  localparam int SETTLE_CYC  = 80;
  localparam int HOLD_CYC    = 400;
  localparam int STALL_LIMIT = 3000;

  // unused register indexes, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct {
    logic [RANGE_W-1:0] mean_range;
    logic [AZ_W-1:0]    centre_az;
  } mean_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [TDATA_W-1:0]    s_axis_tdata = '0;  // range_mm[15:0], azimuth[30:16]
  logic                  s_axis_tuser = 1'b0;  // row_start
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]    m_axis_tdata;  // mean_range[15:0], centre_azimuth[30:16]
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  logic [RANGE_W-1:0]    win_range [WIN_LEN];
  logic signed [15:0]    win_az [WIN_LEN];
  int                    win_fill;
  logic [GATE_W-1:0]     az_gate_sh;
  logic [FRAC_W-1:0]     outlier_sh;
  mean_t                 exp_means[$];

  int                    n_mismatch;
  int                    idle_cycles;
  int                    hold_len;
  bit                    tx_idle_on;
  bit                    rx_idle_on;

  window_trimmed_range_mean_top #(
    .HALF_WINDOW(HALF_WINDOW)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // window update and trimmed-mean prediction for one accepted point
  task automatic take_point(input logic [RANGE_W-1:0] rng, input logic [AZ_W-1:0] az,
                            input logic first);
    logic signed [15:0] ctr;
    int sum, cnt, m1, m2, d, r;
    mean_t m;
    if (first) begin
      win_fill = 0;
      foreach (win_range[k]) begin
        win_range[k] = '0;
        win_az[k] = '0;
      end
    end
    for (int k = 0; k < WIN_LEN - 1; k++) begin
      win_range[k] = win_range[k+1];
      win_az[k] = win_az[k+1];
    end
    win_range[WIN_LEN-1] = rng;
    win_az[WIN_LEN-1] = 16'($signed(az));
    if (win_fill < WIN_LEN) win_fill++;
    if (win_fill < WIN_LEN) return;
    ctr = win_az[HALF_WINDOW];
    sum = 0;
    cnt = 0;
    for (int k = 0; k < WIN_LEN; k++) begin
      d = int'(win_az[k]) - int'(ctr);
      if (d < 0) d = -d;
      if (d <= int'(az_gate_sh)) begin
        sum += int'(win_range[k]);
        cnt++;
      end
    end
    m1 = (cnt != 0) ? sum / cnt : 0;
    sum = 0;
    cnt = 0;
    for (int k = 0; k < WIN_LEN; k++) begin
      d = int'(win_az[k]) - int'(ctr);
      if (d < 0) d = -d;
      r = int'(win_range[k]);
      if (d <= int'(az_gate_sh) && !(r > m1 && (r - m1) * 256 > m1 * int'(outlier_sh))) begin
        sum += r;
        cnt++;
      end
    end
    m2 = (cnt != 0) ? sum / cnt : 0;
    m.mean_range = 16'(m2);
    m.centre_az = ctr[AZ_W-1:0];
    exp_means = {exp_means, m};
  endtask

  task automatic send_point(input logic [RANGE_W-1:0] rng, input logic [AZ_W-1:0] az,
                            input logic first);
    int unsigned gap;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, az, rng};
    s_axis_tuser <= first;
    do @(posedge clk_i); while (!s_axis_tready);
    take_point(rng, az, first);
    gap = tx_idle_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (exp_means.size() == 0);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_AZ_GATE) az_gate_sh = val;
    else if (idx == REG_OUTLIER) outlier_sh = val[FRAC_W-1:0];
  endtask

  // a row of points with slowly moving azimuth, some range spikes
  task automatic send_row(input int len);
    int base, az0, step, rg;
    base = $urandom_range(200, 60000);
    az0 = int'($urandom_range(0, 25736)) - 12868;
    step = $urandom_range(0, 80);
    for (int i = 0; i < len; i++) begin
      rg = base + int'($urandom_range(0, 1000)) - 500;
      if ($urandom_range(0, 7) == 0) rg = $urandom_range(0, 65535);
      if (rg < 0) rg = 0;
      if (rg > 65535) rg = 65535;
      send_point(16'(rg), 15'(az0 + i * step), i == 0);
    end
  endtask

  task automatic test_default_regs();
    logic [RANGE_W-1:0] rngs [8] = '{1000, 1020, 980, 65535, 1000, 0, 1010, 1500};
    int                 azs [8]  = '{0, 10, 20, 30, 40, 50, 90, 100};
    foreach (rngs[i]) send_point(rngs[i], 15'(azs[i]), i == 0);
    // row restart part way into a window
    send_point(16'd2000, 15'(-500), 1'b1);
    send_point(16'd2100, 15'(-490), 1'b0);
    for (int i = 0; i < 7; i++) send_point(16'(3000 + 40 * i), 15'(-100 + 20 * i), i == 0);
    drain();
  endtask

  task automatic test_reg_extremes();
    logic [RANGE_W-1:0] rngs [8] = '{65535, 0, 65535, 1, 65535, 65535, 0, 300};
    int                 azs [8]  = '{-16384, 16383, -12868, 12868, 12868, 16383, -16384, 0};
    write_reg(REG_AZ_GATE, 16'd0);
    write_reg(REG_OUTLIER, 16'd0);
    for (int i = 0; i < 7; i++) send_point(rngs[i], 15'(azs[i]), i == 0);
    drain();
    write_reg(REG_AZ_GATE, 16'hFFFF);
    write_reg(REG_OUTLIER, 16'hFFFF);
    write_reg(REG_SPARE_2, 16'h0000);
    write_reg(REG_SPARE_3, 16'h0000);
    send_point(rngs[7], 15'(azs[7]), 1'b0);
    drain();
  endtask

  task automatic test_back_pressure();
    write_reg(REG_AZ_GATE, AZ_GATE_RST);
    write_reg(REG_OUTLIER, 16'(OUTLIER_RST));
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    hold_len = HOLD_CYC;
    send_row(60);
    drain();
  endtask

  task automatic test_random_rows();
    int unsigned sel;
    int sent, len;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_AZ_GATE, 16'd0);
          write_reg(REG_OUTLIER, 16'd0);
        end
        1: begin
          write_reg(REG_AZ_GATE, 16'hFFFF);
          write_reg(REG_OUTLIER, 16'h00FF);
        end
        default: begin
          sel = $urandom_range(0, 3);
          write_reg(REG_AZ_GATE, (sel == 0) ? 16'(AZ_GATE_RST) :
                                 (sel == 1) ? 16'($urandom_range(0, 65535)) :
                                 16'($urandom_range(0, 200)));
          write_reg(REG_OUTLIER, 16'($urandom_range(0, 65535)));
        end
      endcase
      tx_idle_on = (ph % 3) != 0;
      rx_idle_on = (ph % 4) != 1;
      sent = 0;
      while (sent < 95) begin
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
          send_point(16'($urandom()), 15'($urandom()), $urandom_range(0, 7) == 0);
          sent++;
        end else begin
          len = (sel == 1) ? $urandom_range(1, 6) : $urandom_range(7, 24);
          send_row(len);
          sent += len;
        end
      end
      drain();
    end
  endtask

  // sink side: random stall before each word, plus one long hold on request
  initial begin
    int unsigned stall;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_len > 0) begin
        stall = hold_len;
        hold_len = 0;
      end else begin
        stall = rx_idle_on ? $urandom_range(0, 14) : 0;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin
    mean_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (exp_means.size() == 0) begin
        $error("unexpected output word %h", m_axis_tdata);
        n_mismatch++;
      end else begin
        want = exp_means.pop_front();
        if (m_axis_tdata[15:0] !== want.mean_range) begin
          $error("mean_range: expected %0d, got %0d", want.mean_range, m_axis_tdata[15:0]);
          n_mismatch++;
        end
        if (m_axis_tdata[30:16] !== want.centre_az) begin
          $error("centre_azimuth: expected %0d, got %0d", $signed(want.centre_az),
                 $signed(m_axis_tdata[30:16]));
          n_mismatch++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    n_mismatch = 0;
    hold_len = 0;
    win_fill = 0;
    az_gate_sh = AZ_GATE_RST;
    outlier_sh = OUTLIER_RST;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    foreach (win_range[k]) begin
      win_range[k] = '0;
      win_az[k] = '0;
    end
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_default_regs();
    test_reg_extremes();
    test_back_pressure();
    test_random_rows();
    if (n_mismatch == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
